>>> design/kfa_pkg.sv
// shared widths, request and status codes, register indexes and the loop config struct
// for the keyframe animation sequencer; no dependencies
package kfa_pkg;

  localparam int MAX_FRAMES_DEF = 256;
  localparam int TIME_BITS_DEF  = 16;

  localparam int REQ_W  = 3;
  localparam int DUR_W  = 16;
  localparam int TGT_W  = 24;
  localparam int ST_W   = 2;
  localparam int FRM_W  = 8;
  localparam int ELT_W  = 16;
  localparam int LOOP_W = 9;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef logic [REQ_W-1:0] req_t;
  typedef logic [ST_W-1:0]  status_t;
  typedef logic [1:0]       reg_idx_t;

  localparam req_t REQ_APPEND = 3'd0;
  localparam req_t REQ_FWD    = 3'd1;
  localparam req_t REQ_BACK   = 3'd2;
  localparam req_t REQ_JUMP_T = 3'd3;
  localparam req_t REQ_JUMP_K = 3'd4;
  localparam req_t REQ_START  = 3'd5;
  localparam req_t REQ_END    = 3'd6;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_END   = 2'd1;
  localparam status_t ST_RANGE = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  localparam reg_idx_t REG_LOOP_EN    = 2'd0;
  localparam reg_idx_t REG_LOOP_FIRST = 2'd1;
  localparam reg_idx_t REG_LOOP_LAST  = 2'd2;

  localparam logic [LOOP_W-1:0] LOOP_LAST_RST = 9'h1FF;

  typedef struct packed {
    logic              loop_en;
    logic [LOOP_W-1:0] loop_first;
    logic [LOOP_W-1:0] loop_last;
  } loop_cfg_t;

endpackage

>>> design/kfa_if.sv
// valid/ready channel interfaces for request beats and result beats
// depends on kfa_pkg
interface kfa_in_if import kfa_pkg::*; ();
  logic              valid;
  logic              ready;
  req_t              req_type;
  logic [DUR_W-1:0]  duration;
  logic [TGT_W-1:0]  target;

  modport source (output valid, req_type, duration, target, input ready);
  modport sink (input valid, req_type, duration, target, output ready);
endinterface

interface kfa_out_if import kfa_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [FRM_W-1:0]  frame_index;
  logic [ELT_W-1:0]  elapsed_ticks;

  modport source (output valid, status, frame_index, elapsed_ticks, input ready);
  modport sink (input valid, status, frame_index, elapsed_ticks, output ready);
endinterface

>>> design/keyframe_animation_sequencer_top.sv
// Keyframe animation sequencer: a table of frame durations filled by append beats and a
// playback position (frame, elapsed ticks) moved by tick, jump and rewind requests. One
// request is worked at a time by a small sequencer around one shared add/subtract unit and
// a duration ram with registered read. Append, keyframe jump, rewind to start and unused
// codes finish directly, as do a tick off the table, a backward tick with nonzero status
// and rewind to end or jump to time on an empty table. Rewind to end and a backward tick
// to another frame read that frame's duration from ram. Jump to time reads one table
// entry per cycle through the shared subtractor. A finished result waits in an output
// register while the next request is accepted. The user must write loop registers over
// apb only while the block is idle; the block itself does not enforce this.
module keyframe_animation_sequencer_top import kfa_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  kfa_in_if.sink            in_ch,
  kfa_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int FB  = $clog2(MAX_FRAMES);
  localparam int FLW = $clog2(MAX_FRAMES + 1);
  localparam int LW  = ((FLW > LOOP_W) ? FLW : LOOP_W) + 2;
  localparam int AW  = (TIME_BITS > TGT_W) ? TIME_BITS : TGT_W;
  localparam logic [FLW-1:0] FL_FULL = FLW'(MAX_FRAMES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FWD   = 4'd1;
  localparam logic [3:0] S_INC   = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_LDRD  = 4'd4;
  localparam logic [3:0] S_LOAD  = 4'd5;
  localparam logic [3:0] S_SCAN0 = 4'd6;
  localparam logic [3:0] S_SCAN  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  loop_cfg_t cfg;

  logic [3:0]           state_r, state_nxt;
  logic [FLW-1:0]       fl_r, fl_nxt;
  logic [FB-1:0]        cf_r, cf_nxt;
  logic [TIME_BITS-1:0] tc_r, tc_nxt;
  status_t              st_r, st_nxt;
  logic                 app_r, app_nxt;
  logic [TGT_W-1:0]     rem_r, rem_nxt;
  logic [FB-1:0]        scan_r, scan_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_st_r;
  logic [FRM_W-1:0]     out_frm_r;
  logic [ELT_W-1:0]     out_elt_r;

  logic                 in_fire;
  logic                 out_load;
  logic                 ram_we;
  logic [FB-1:0]        ram_ra;
  logic [TIME_BITS-1:0] ram_rd;

  logic [AW-1:0]        alu_a, alu_b, alu_res;
  logic                 alu_sub, alu_borrow;

  logic [FLW-1:0]       cf_ext, cf_inc, fl_m1;
  logic                 off_tab;
  logic signed [LW-1:0] fl_s, lf_s, ll_s, cf_s, lstart, lend;
  logic                 start_ok, end_ok, at_lend;

  kfa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kfa_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_dur_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fl_r[FB-1:0]),
    .wdata (TIME_BITS'(in_ch.duration)),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  kfa_alu #(
    .W (AW)
  ) u_alu (
    .sub    (alu_sub),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid & (state_r == S_IDLE);
  assign out_load    = (state_r == S_DONE) & (~out_valid_r | out_ch.ready);
  assign ram_we      = in_fire & (in_ch.req_type == REQ_APPEND) & (fl_r != FL_FULL);

  // position and loop bounds
  assign cf_ext   = FLW'(cf_r);
  assign cf_inc   = cf_ext + FLW'(1);
  assign fl_m1    = fl_r - FLW'(1);
  assign off_tab  = (cf_ext >= fl_r);
  assign fl_s     = $signed({{(LW-FLW){1'b0}}, fl_r});
  assign cf_s     = $signed({{(LW-FB){1'b0}}, cf_r});
  assign lf_s     = $signed({{(LW-LOOP_W){cfg.loop_first[LOOP_W-1]}}, cfg.loop_first});
  assign ll_s     = $signed({{(LW-LOOP_W){cfg.loop_last[LOOP_W-1]}}, cfg.loop_last});
  assign lstart   = lf_s[LW-1] ? (lf_s + fl_s) : lf_s;
  assign lend     = fl_s + ll_s;
  assign start_ok = ~lstart[LW-1] & (lstart < fl_s);
  assign end_ok   = ~lend[LW-1] & (lend < fl_s);
  assign at_lend  = (cf_s == lend);

  always_comb begin
    case (state_r)
      S_SCAN0: ram_ra = '0;
      S_SCAN:  ram_ra = scan_r + FB'(1);
      default: ram_ra = cf_r;
    endcase
  end

  always_comb begin
    alu_sub = 1'b0;
    alu_a   = '0;
    alu_b   = '0;
    case (state_r)
      S_FWD: begin
        alu_sub = 1'b1;
        alu_a   = AW'(tc_r);
        alu_b   = AW'(ram_rd);
      end
      S_INC: begin
        alu_a = AW'(tc_r);
        alu_b = AW'(1);
      end
      S_DEC: begin
        alu_sub = 1'b1;
        alu_a   = AW'(tc_r);
        alu_b   = AW'(1);
      end
      S_SCAN: begin
        alu_sub = 1'b1;
        alu_a   = AW'(rem_r);
        alu_b   = AW'(ram_rd);
      end
      default: alu_sub = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    fl_nxt    = fl_r;
    cf_nxt    = cf_r;
    tc_nxt    = tc_r;
    st_nxt    = st_r;
    app_nxt   = app_r;
    rem_nxt   = rem_r;
    scan_nxt  = scan_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          app_nxt   = 1'b0;
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
          case (in_ch.req_type)
            REQ_APPEND: begin
              if (fl_r == FL_FULL) begin
                st_nxt = ST_FULL;
              end else begin
                fl_nxt  = fl_r + FLW'(1);
                app_nxt = 1'b1;
              end
            end
            REQ_FWD: begin
              if (off_tab) begin
                st_nxt = ST_RANGE;
              end else begin
                state_nxt = S_FWD;
              end
            end
            REQ_BACK: begin
              if (off_tab) begin
                st_nxt = ST_RANGE;
              end else if (tc_r != '0) begin
                state_nxt = S_DEC;
              end else if (cfg.loop_en && cf_r == '0) begin
                if (!end_ok) begin
                  st_nxt = ST_RANGE;
                end else begin
                  cf_nxt    = lend[FB-1:0];
                  state_nxt = S_LDRD;
                end
              end else if (cf_r != '0) begin
                cf_nxt    = cf_r - FB'(1);
                state_nxt = S_LDRD;
              end else begin
                st_nxt = ST_END;
              end
            end
            REQ_JUMP_T: begin
              if (fl_r == '0) begin
                st_nxt = ST_RANGE;
              end else begin
                rem_nxt   = in_ch.target;
                scan_nxt  = '0;
                state_nxt = S_SCAN0;
              end
            end
            REQ_JUMP_K: begin
              if (in_ch.target >= TGT_W'(fl_r)) begin
                st_nxt = ST_RANGE;
              end else begin
                cf_nxt = in_ch.target[FB-1:0];
                tc_nxt = '0;
              end
            end
            REQ_START: begin
              cf_nxt = '0;
              tc_nxt = '0;
            end
            REQ_END: begin
              if (fl_r != '0) begin
                cf_nxt    = fl_m1[FB-1:0];
                state_nxt = S_LDRD;
              end else begin
                cf_nxt = '0;
                tc_nxt = '0;
              end
            end
            default: st_nxt = ST_RANGE;
          endcase
        end
      end
      S_FWD: begin
        state_nxt = S_DONE;
        if (alu_borrow) begin
          state_nxt = S_INC;
        end else if (cfg.loop_en && at_lend) begin
          if (!start_ok) begin
            st_nxt = ST_RANGE;
          end else begin
            cf_nxt = lstart[FB-1:0];
            tc_nxt = '0;
          end
        end else if (cf_inc < fl_r) begin
          cf_nxt = cf_inc[FB-1:0];
          tc_nxt = '0;
        end else begin
          st_nxt = ST_END;
        end
      end
      S_INC, S_DEC: begin
        tc_nxt    = alu_res[TIME_BITS-1:0];
        state_nxt = S_DONE;
      end
      S_LDRD: state_nxt = S_LOAD;
      S_LOAD: begin
        tc_nxt    = ram_rd;
        state_nxt = S_DONE;
      end
      S_SCAN0: state_nxt = S_SCAN;
      S_SCAN: begin
        // running remainder drops below this frame's duration: target lies inside it
        if (alu_borrow) begin
          cf_nxt    = scan_r;
          tc_nxt    = TIME_BITS'(rem_r);
          state_nxt = S_DONE;
        end else if (FLW'(scan_r) == fl_m1) begin
          cf_nxt    = scan_r;
          tc_nxt    = ram_rd;
          st_nxt    = ST_RANGE;
          state_nxt = S_DONE;
        end else begin
          rem_nxt  = alu_res[TGT_W-1:0];
          scan_nxt = scan_r + FB'(1);
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fl_r        <= '0;
      cf_r        <= '0;
      tc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fl_r        <= fl_nxt;
      cf_r        <= cf_nxt;
      tc_r        <= tc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    app_r  <= app_nxt;
    rem_r  <= rem_nxt;
    scan_r <= scan_nxt;
    if (out_load) begin
      out_st_r  <= st_r;
      out_frm_r <= app_r ? FRM_W'(fl_m1) : FRM_W'(cf_r);
      out_elt_r <= ELT_W'(tc_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.frame_index   = out_frm_r;
  assign out_ch.elapsed_ticks = out_elt_r;

`ifndef SYNTHESIS
  a_cf_on_table: assert property (@(posedge clk) disable iff (!rst_n)
    (FLW'(cf_r) < fl_r) || (cf_r == '0))
    else $error("current frame off the loaded table");

  a_fl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fl_r <= FL_FULL)
    else $error("frame count beyond table depth");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside done state");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("sequencer idle right after accepting a beat");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (FLW'(scan_r) < fl_r))
    else $error("time search ran past the loaded frames");
`endif

endmodule

>>> design/kfa_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module kfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/kfa_alu.sv
// shared add/subtract unit with borrow out, used for tick steps and the time search
// no dependencies
module kfa_alu #(
  parameter int W = 24
) (
  input  logic         sub,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] res,
  output logic         borrow
);

  logic [W:0] sum;

  assign sum    = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
  assign res    = sum[W-1:0];
  assign borrow = sub & ~sum[W];

endmodule

>>> design/kfa_cfg.sv
// apb register file for the loop registers
// depends on kfa_pkg
module kfa_cfg import kfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output loop_cfg_t         cfg
);

  loop_cfg_t cfg_r;
  loop_cfg_t cfg_nxt;
  reg_idx_t  idx;
  logic      wr;

  assign idx    = paddr[CFG_AW-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_LOOP_EN:    cfg_nxt.loop_en    = pwdata[0];
        REG_LOOP_FIRST: cfg_nxt.loop_first = pwdata[LOOP_W-1:0];
        REG_LOOP_LAST:  cfg_nxt.loop_last  = pwdata[LOOP_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.loop_en    <= 1'b0;
      cfg_r.loop_first <= '0;
      cfg_r.loop_last  <= LOOP_LAST_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_LOOP_EN:    prdata = {{(CFG_DW-1){1'b0}}, cfg_r.loop_en};
      REG_LOOP_FIRST: prdata = {{(CFG_DW-LOOP_W){cfg_r.loop_first[LOOP_W-1]}},
                                cfg_r.loop_first};
      REG_LOOP_LAST:  prdata = {{(CFG_DW-LOOP_W){cfg_r.loop_last[LOOP_W-1]}},
                                cfg_r.loop_last};
      default:        prdata = '0;
    endcase
  end

endmodule
